@@ rtl/postfix_expression_evaluator_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the postfix expression evaluator.
// Each macro expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define PFX_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("pfx invariant violated");

// An implication checked in the same cycle, outside reset.
`define PFX_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfx implication violated");

`endif

@@ rtl/pfx_pkg.sv @@
// ----------------------------------------------------------------------------
// pfx_pkg
// Shared types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfx_pkg;

   // Operand stack geometry.
   localparam int STACK_DEPTH = 64;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DATA_W      = 32;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Iterative divider step counter.
   localparam int DIV_CNT_W   = $clog2(DATA_W);

   // ASCII codes of the recognized symbols.
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   // Symbol classes produced by the front.
   typedef enum logic [2:0] {
      KIND_DIGIT   = 3'd0,
      KIND_ADD     = 3'd1,
      KIND_SUB     = 3'd2,
      KIND_MUL     = 3'd3,
      KIND_DIV     = 3'd4,
      KIND_REM     = 3'd5,
      KIND_INVALID = 3'd6
   } kind_type;

   // One classified command as held in the queue.
   typedef struct packed {
      kind_type   kind;
      logic [3:0] digit;
      logic       last;
   } cmd_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_UNDERFLOW = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_DIVZERO   = 3'd3,
      ST_INVALID   = 3'd4
   } status_type;

   // Back end sequencer states.
   typedef enum logic [3:0] {
      BK_IDLE  = 4'd0,
      BK_RD_B  = 4'd1,
      BK_RD_A  = 4'd2,
      BK_EXEC  = 4'd3,
      BK_DIV   = 4'd4,
      BK_PUSH  = 4'd5,
      BK_FINAL = 4'd6,
      BK_FREAD = 4'd7,
      BK_EMIT  = 4'd8
   } back_state_type;

   // Status of the back end, observed at the top level.
   typedef struct packed {
      logic            emit;
      logic [SP_W-1:0] sp;
   } bk_status_type;

endpackage

`default_nettype wire

@@ rtl/pfx_front.sv @@
// ----------------------------------------------------------------------------
// pfx_front
// Accepts input transactions and classifies each symbol into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module pfx_front (
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic [7:0]      req_symbol,
   input  wire logic            req_last,
   input  wire logic            q_full,
   output logic                 q_push,
   output pfx_pkg::cmd_type     q_data
);

   // Accept whenever the queue has room.
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // Decode the symbol into a command class and digit value.
   always_comb begin
      q_data.last  = req_last;
      q_data.digit = 4'(req_symbol - pfx_pkg::CH_ZERO);
      priority if (req_symbol >= pfx_pkg::CH_ZERO && req_symbol <= pfx_pkg::CH_NINE) begin
         q_data.kind = pfx_pkg::KIND_DIGIT;
      end else if (req_symbol == pfx_pkg::CH_PLUS) begin
         q_data.kind = pfx_pkg::KIND_ADD;
      end else if (req_symbol == pfx_pkg::CH_MINUS) begin
         q_data.kind = pfx_pkg::KIND_SUB;
      end else if (req_symbol == pfx_pkg::CH_STAR) begin
         q_data.kind = pfx_pkg::KIND_MUL;
      end else if (req_symbol == pfx_pkg::CH_SLASH) begin
         q_data.kind = pfx_pkg::KIND_DIV;
      end else if (req_symbol == pfx_pkg::CH_PERCENT) begin
         q_data.kind = pfx_pkg::KIND_REM;
      end else begin
         q_data.kind = pfx_pkg::KIND_INVALID;
      end
   end

endmodule

`default_nettype wire

@@ rtl/pfx_queue.sv @@
// ----------------------------------------------------------------------------
// pfx_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pfx_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire pfx_pkg::cmd_type push_data,
   input  wire logic             pop,
   output pfx_pkg::cmd_type      head,
   output logic                  full,
   output logic                  empty
);

   pfx_pkg::cmd_type                   entry_ff [pfx_pkg::QUEUE_DEPTH];
   logic [pfx_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [pfx_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [pfx_pkg::QCNT_W-1:0]         count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   assign full    = (count_ff == pfx_pkg::QCNT_W'(pfx_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and count updates with explicit wrap.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == pfx_pkg::QPTR_W'(pfx_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + pfx_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == pfx_pkg::QPTR_W'(pfx_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + pfx_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + pfx_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - pfx_pkg::QCNT_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/pfx_divider.sv @@
// ----------------------------------------------------------------------------
// pfx_divider
// Unsigned restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfx_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [pfx_pkg::DATA_W-1:0]  dividend,
   input  wire logic [pfx_pkg::DATA_W-1:0]  divisor,
   output logic                             busy,
   output logic                             done,
   output logic [pfx_pkg::DATA_W-1:0]       quotient,
   output logic [pfx_pkg::DATA_W-1:0]       remainder
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [pfx_pkg::DIV_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [pfx_pkg::DATA_W-1:0]          rem_ff, rem_in;
   logic [pfx_pkg::DATA_W-1:0]          quo_ff, quo_in;
   logic [pfx_pkg::DATA_W-1:0]          dsr_ff, dsr_in;
   logic [pfx_pkg::DATA_W:0]            shifted;
   logic [pfx_pkg::DATA_W:0]            diff;

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   // One trial subtraction of the shifted partial remainder.
   assign shifted = {rem_ff, quo_ff[pfx_pkg::DATA_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[pfx_pkg::DATA_W]) begin
            rem_in = diff[pfx_pkg::DATA_W-1:0];
            quo_in = {quo_ff[pfx_pkg::DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[pfx_pkg::DATA_W-1:0];
            quo_in = {quo_ff[pfx_pkg::DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + pfx_pkg::DIV_CNT_W'(1);
         if (cnt_ff == pfx_pkg::DIV_CNT_W'(pfx_pkg::DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

endmodule

`default_nettype wire

@@ rtl/pfx_back.sv @@
// ----------------------------------------------------------------------------
// pfx_back
// Executes queued commands against the operand stack and emits results.
// ----------------------------------------------------------------------------
`default_nettype none

module pfx_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire pfx_pkg::cmd_type            q_head,
   input  wire logic                        q_empty,
   output logic                             q_pop,
   output logic                             div_start,
   output logic [pfx_pkg::DATA_W-1:0]       div_dividend,
   output logic [pfx_pkg::DATA_W-1:0]       div_divisor,
   input  wire logic                        div_done,
   input  wire logic [pfx_pkg::DATA_W-1:0]  div_quotient,
   input  wire logic [pfx_pkg::DATA_W-1:0]  div_remainder,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [31:0]               rsp_value,
   output logic [2:0]                       rsp_status,
   output pfx_pkg::bk_status_type           bk_stat
);

   localparam int SP_W   = pfx_pkg::SP_W;
   localparam int ADDR_W = pfx_pkg::ADDR_W;
   localparam int DW     = pfx_pkg::DATA_W;

   pfx_pkg::back_state_type     state_ff, state_in;
   logic [SP_W-1:0]             sp_ff, sp_in;
   pfx_pkg::status_type         status_ff, status_in;
   pfx_pkg::kind_type           op_ff, op_in;
   logic                        last_ff, last_in;
   logic [DW-1:0]               a_ff, a_in;
   logic [DW-1:0]               b_ff, b_in;
   logic [DW-1:0]               res_ff, res_in;
   logic [DW-1:0]               fin_val_ff, fin_val_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]               rsp_value_ff, rsp_value_in;
   pfx_pkg::status_type         rsp_status_ff, rsp_status_in;

   logic [DW-1:0]               stack_ff [pfx_pkg::STACK_DEPTH];
   logic [DW-1:0]               rd_data_ff;
   logic [ADDR_W-1:0]           rd_addr;
   logic                        mem_we;
   logic [ADDR_W-1:0]           mem_waddr;
   logic [DW-1:0]               mem_wdata;

   logic [SP_W-1:0]             sp_m1;
   logic [SP_W-1:0]             sp_m2;
   logic                        sp_full;
   logic                        sp_ge2;
   logic                        sp_zero;
   logic                        head_is_op;
   logic                        op_is_divrem;
   logic                        out_free;
   logic                        a_neg;
   logic                        b_neg;

   // Keep the first error of an expression.
   function automatic pfx_pkg::status_type note_error(input pfx_pkg::status_type cur,
                                                      input pfx_pkg::status_type code);
      return (cur == pfx_pkg::ST_OK) ? code : cur;
   endfunction

   // Stack pointer derived values.
   assign sp_m1   = sp_ff - SP_W'(1);
   assign sp_m2   = sp_ff - SP_W'(2);
   assign sp_full = (sp_ff >= SP_W'(pfx_pkg::STACK_DEPTH));
   assign sp_ge2  = (sp_ff >= SP_W'(2));
   assign sp_zero = (sp_ff == '0);

   // Command and operand classification.
   assign head_is_op   = (q_head.kind == pfx_pkg::KIND_ADD) ||
                         (q_head.kind == pfx_pkg::KIND_SUB) ||
                         (q_head.kind == pfx_pkg::KIND_MUL) ||
                         (q_head.kind == pfx_pkg::KIND_DIV) ||
                         (q_head.kind == pfx_pkg::KIND_REM);
   assign op_is_divrem = (op_ff == pfx_pkg::KIND_DIV) || (op_ff == pfx_pkg::KIND_REM);
   assign a_neg        = a_ff[DW-1];
   assign b_neg        = b_ff[DW-1];
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // Divider operands are the magnitudes of the popped values.
   assign div_dividend = a_neg ? (DW'(0) - a_ff) : a_ff;
   assign div_divisor  = b_neg ? (DW'(0) - b_ff) : b_ff;

   // Stack read address: right operand first, then left operand.
   assign rd_addr = (state_ff == pfx_pkg::BK_RD_B) ? sp_m2[ADDR_W-1:0] : sp_m1[ADDR_W-1:0];

   // Result channel and status.
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = signed'(rsp_value_ff);
   assign rsp_status   = rsp_status_ff;
   assign bk_stat.emit = (state_ff == pfx_pkg::BK_EMIT);
   assign bk_stat.sp   = sp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfx_pkg::BK_IDLE: begin
            if (!q_empty) begin
               if (head_is_op && sp_ge2) begin
                  state_in = pfx_pkg::BK_RD_B;
               end else if (q_head.last) begin
                  state_in = pfx_pkg::BK_FINAL;
               end
            end
         end
         pfx_pkg::BK_RD_B: begin
            state_in = pfx_pkg::BK_RD_A;
         end
         pfx_pkg::BK_RD_A: begin
            state_in = pfx_pkg::BK_EXEC;
         end
         pfx_pkg::BK_EXEC: begin
            if (op_is_divrem && (b_ff != '0)) begin
               state_in = pfx_pkg::BK_DIV;
            end else begin
               state_in = pfx_pkg::BK_PUSH;
            end
         end
         pfx_pkg::BK_DIV: begin
            if (div_done) begin
               state_in = pfx_pkg::BK_PUSH;
            end
         end
         pfx_pkg::BK_PUSH: begin
            state_in = last_ff ? pfx_pkg::BK_FINAL : pfx_pkg::BK_IDLE;
         end
         pfx_pkg::BK_FINAL: begin
            state_in = sp_zero ? pfx_pkg::BK_EMIT : pfx_pkg::BK_FREAD;
         end
         pfx_pkg::BK_FREAD: begin
            state_in = pfx_pkg::BK_EMIT;
         end
         pfx_pkg::BK_EMIT: begin
            if (out_free) begin
               state_in = pfx_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = pfx_pkg::BK_IDLE;
         end
      endcase
   end

   // Outputs and datapath next values.
   always_comb begin
      q_pop         = 1'b0;
      div_start     = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = sp_ff[ADDR_W-1:0];
      mem_wdata     = res_ff;
      sp_in         = sp_ff;
      status_in     = status_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      res_in        = res_ff;
      fin_val_in    = fin_val_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         pfx_pkg::BK_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               op_in   = q_head.kind;
               last_in = q_head.last;
               if (q_head.kind == pfx_pkg::KIND_DIGIT) begin
                  if (sp_full) begin
                     status_in = note_error(status_ff, pfx_pkg::ST_OVERFLOW);
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = DW'(q_head.digit);
                     sp_in     = sp_ff + SP_W'(1);
                  end
               end else if (q_head.kind == pfx_pkg::KIND_INVALID) begin
                  status_in = note_error(status_ff, pfx_pkg::ST_INVALID);
               end else if (!sp_ge2) begin
                  status_in = note_error(status_ff, pfx_pkg::ST_UNDERFLOW);
               end
            end
         end
         pfx_pkg::BK_RD_B: begin
            b_in = rd_data_ff;
         end
         pfx_pkg::BK_RD_A: begin
            a_in = rd_data_ff;
         end
         pfx_pkg::BK_EXEC: begin
            unique case (op_ff)
               pfx_pkg::KIND_ADD: res_in = a_ff + b_ff;
               pfx_pkg::KIND_SUB: res_in = a_ff - b_ff;
               pfx_pkg::KIND_MUL: res_in = a_ff * b_ff;
               default: begin
                  // Division and remainder: a zero divisor yields zero.
                  if (b_ff == '0) begin
                     res_in    = '0;
                     status_in = note_error(status_ff, pfx_pkg::ST_DIVZERO);
                  end else begin
                     div_start = 1'b1;
                  end
               end
            endcase
         end
         pfx_pkg::BK_DIV: begin
            // Quotient takes the sign of the product, remainder that of the dividend.
            if (div_done) begin
               if (op_ff == pfx_pkg::KIND_DIV) begin
                  res_in = (a_neg != b_neg) ? (DW'(0) - div_quotient) : div_quotient;
               end else begin
                  res_in = a_neg ? (DW'(0) - div_remainder) : div_remainder;
               end
            end
         end
         pfx_pkg::BK_PUSH: begin
            // Two entries popped, one pushed: the write goes where the left operand was.
            mem_we    = 1'b1;
            mem_waddr = sp_m2[ADDR_W-1:0];
            mem_wdata = res_ff;
            sp_in     = sp_m1;
         end
         pfx_pkg::BK_FINAL: begin
            if (sp_zero) begin
               status_in  = note_error(status_ff, pfx_pkg::ST_UNDERFLOW);
               fin_val_in = '0;
            end
         end
         pfx_pkg::BK_FREAD: begin
            fin_val_in = rd_data_ff;
         end
         pfx_pkg::BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = fin_val_ff;
               rsp_status_in = status_ff;
               sp_in         = '0;
               status_in     = pfx_pkg::ST_OK;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfx_pkg::BK_IDLE;
         sp_ff        <= '0;
         status_ff    <= pfx_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      last_ff       <= last_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      res_ff        <= res_in;
      fin_val_ff    <= fin_val_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Operand stack memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= stack_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/postfix_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix expression given one ASCII character per transaction.
// A front stage classifies each symbol and queues it in a four-entry command
// queue; the back stage runs it against a 64-entry operand stack memory.
// A digit is taken from the queue and pushed in the idle state; + - * read two
// stack entries, execute and write back, and / % run the 32-step restoring
// divider between execute and write back. A transaction with last set
// then reads the top of stack (skipped on an empty stack) and loads the
// output register, which then holds value and sticky status until taken.
// While the back works, the front keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "postfix_expression_evaluator_assert.svh"

module postfix_expression_evaluator (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_symbol,
   input  wire logic                req_last,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [31:0]       rsp_value,
   output logic [2:0]               rsp_status
);

   pfx_pkg::cmd_type                  q_data;
   pfx_pkg::cmd_type                  q_head;
   logic                              q_push;
   logic                              q_pop;
   logic                              q_full;
   logic                              q_empty;
   logic                              div_start;
   logic                              div_busy;
   logic                              div_done;
   logic [pfx_pkg::DATA_W-1:0]        div_dividend;
   logic [pfx_pkg::DATA_W-1:0]        div_divisor;
   logic [pfx_pkg::DATA_W-1:0]        div_quotient;
   logic [pfx_pkg::DATA_W-1:0]        div_remainder;
   pfx_pkg::bk_status_type            bk_stat;

   // Symbol classification and input handshake.
   pfx_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_symbol (req_symbol),
      .req_last   (req_last),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_data)
   );

   // Command queue between front and back.
   pfx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Shared iterative divider.
   pfx_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // Stack sequencer and result register.
   pfx_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_head        (q_head),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .div_start     (div_start),
      .div_dividend  (div_dividend),
      .div_divisor   (div_divisor),
      .div_done      (div_done),
      .div_quotient  (div_quotient),
      .div_remainder (div_remainder),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status),
      .bk_stat       (bk_stat)
   );

   // The stack pointer never passes the stack depth.
   `PFX_ASSERT_ALWAYS(a_sp_bound, clock, reset, bk_stat.sp <= pfx_pkg::SP_W'(pfx_pkg::STACK_DEPTH))
   // The back never pops an empty queue.
   `PFX_ASSERT_IMPLIES(a_pop_nonempty, clock, reset, q_pop, !q_empty)
   // The divider is never restarted while it is still iterating.
   `PFX_ASSERT_IMPLIES(a_div_idle_start, clock, reset, div_start, !div_busy)
   // A new result transaction appears only after the emit step.
   `PFX_ASSERT_IMPLIES(a_rsp_from_emit, clock, reset, $rose(rsp_valid), $past(bk_stat.emit))

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix expression evaluator testbench
// Feeds postfix expressions one character per transaction, with random gaps
// on the request side and random stalls on the response side. A behavioral
// copy of the operand stack predicts every response, and each response is
// checked field by field against the oldest prediction. Expressions are
// mostly well formed, with broken, noisy, overflowing and wrapping ones mixed in.
// ----------------------------------------------------------------------------

module testbench;
   import pfx_pkg::*;

   // A character waiting to be driven, and a predicted response.
   typedef struct {
      logic [7:0] symbol;
      logic       last;
      bit         drain;
   } char_item_t;

   typedef struct {
      logic [31:0] value;
      status_type  status;
   } eval_result_t;

   localparam int RANDOM_CHARS = 1750;
   localparam int TAIL_CYCLES  = 60;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_symbol = 8'd0;
   logic               req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_value;
   logic [2:0]         rsp_status;

   postfix_expression_evaluator dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_symbol (req_symbol),
      .req_last   (req_last),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   // Behavioral operand stack.
   logic [31:0]  operand_mem [STACK_DEPTH];
   int unsigned  operand_count = 0;
   status_type   sticky_code = ST_OK;
   eval_result_t expected_results [$];

   // Stimulus and handshake bookkeeping.
   char_item_t   pending_chars [$];
   logic [7:0]   expr_chars [$];
   int           chars_queued = 0;
   int           chars_issued = 0;
   int           chars_accepted = 0;
   int           results_seen = 0;
   int           gap_left = 0;
   int           stall_left = 0;
   bit           req_calm = 1'b0;
   bit           rsp_calm = 1'b0;
   int           mismatches = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor: error codes are sticky until the end of an expression.
   task automatic note_fault(status_type code);
      if (sticky_code == ST_OK)
         sticky_code = code;
   endtask

   task automatic push_operand(logic [31:0] operand);
      if (operand_count >= STACK_DEPTH) begin
         note_fault(ST_OVERFLOW);
      end else begin
         operand_mem[operand_count] = operand;
         operand_count++;
      end
   endtask

   function automatic bit is_operator(logic [7:0] sym);
      return sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR ||
             sym == CH_SLASH || sym == CH_PERCENT;
   endfunction

   task automatic evaluate_char(logic [7:0] sym, logic last);
      logic [31:0]  lhs;
      logic [31:0]  rhs;
      logic [31:0]  outcome;
      logic [31:0]  lhs_mag;
      logic [31:0]  rhs_mag;
      eval_result_t result;
      if (sym >= CH_ZERO && sym <= CH_NINE) begin
         push_operand(32'(sym - CH_ZERO));
      end else if (is_operator(sym)) begin
         if (operand_count < 2) begin
            note_fault(ST_UNDERFLOW);
         end else begin
            rhs = operand_mem[operand_count - 1];
            lhs = operand_mem[operand_count - 2];
            operand_count -= 2;
            lhs_mag = lhs[31] ? 32'd0 - lhs : lhs;
            rhs_mag = rhs[31] ? 32'd0 - rhs : rhs;
            if (sym == CH_PLUS) begin
               outcome = lhs + rhs;
            end else if (sym == CH_MINUS) begin
               outcome = lhs - rhs;
            end else if (sym == CH_STAR) begin
               outcome = lhs * rhs;
            end else if (rhs == 32'd0) begin
               note_fault(ST_DIVZERO);
               outcome = 32'd0;
            end else if (sym == CH_SLASH) begin
               // Truncate toward zero; the most negative value over -1 wraps.
               outcome = lhs_mag / rhs_mag;
               if (lhs[31] != rhs[31])
                  outcome = 32'd0 - outcome;
            end else begin
               // The remainder takes the sign of the dividend.
               outcome = lhs_mag % rhs_mag;
               if (lhs[31])
                  outcome = 32'd0 - outcome;
            end
            push_operand(outcome);
         end
      end else begin
         note_fault(ST_INVALID);
      end

      // The closing character pops the top and clears the stack.
      if (last) begin
         result.value = 32'd0;
         if (operand_count == 0) begin
            note_fault(ST_UNDERFLOW);
         end else begin
            operand_count--;
            result.value = operand_mem[operand_count];
         end
         result.status = sticky_code;
         expected_results.push_back(result);
         operand_count = 0;
         sticky_code = ST_OK;
      end
   endtask

   // Expression builders.
   function automatic logic [7:0] random_operator();
      case ($urandom_range(0, 4))
         0: return CH_PLUS;
         1: return CH_MINUS;
         2: return CH_STAR;
         3: return CH_SLASH;
         default: return CH_PERCENT;
      endcase
   endfunction

   function automatic logic [7:0] random_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   task automatic add_text(string text);
      for (int i = 0; i < text.len(); i++)
         expr_chars.push_back(text[i]);
   endtask

   // Well formed operand tree: operators only once two operands are held.
   task automatic add_operand_tree(int operators);
      int digits_left;
      int ops_left;
      int held;
      digits_left = operators + 1;
      ops_left = operators;
      held = 0;
      while (digits_left + ops_left > 0) begin
         if (digits_left > 0 && (held < 2 || ops_left == 0 || $urandom_range(0, 1))) begin
            expr_chars.push_back(random_digit());
            digits_left--;
            held++;
         end else begin
            expr_chars.push_back(random_operator());
            ops_left--;
            held--;
         end
      end
   endtask

   // Builds 2 * 8^10, which wraps to the most negative value.
   task automatic add_min_value_case();
      expr_chars.push_back(CH_ZERO + 8'd2);
      repeat (10) begin
         expr_chars.push_back(CH_ZERO + 8'd8);
         expr_chars.push_back(CH_STAR);
      end
      case ($urandom_range(0, 3))
         0: add_text("01-/");
         1: add_text("01-%");
         2: begin
            expr_chars.push_back(random_digit());
            expr_chars.push_back(random_operator());
         end
         default: ;
      endcase
   endtask

   // Moves the built expression to the pending queue, last flag on its end.
   task automatic commit_expr(bit drain);
      char_item_t item;
      for (int i = 0; i < expr_chars.size(); i++) begin
         item.symbol = expr_chars[i];
         item.last = (i == expr_chars.size() - 1);
         item.drain = drain && (i == 0);
         pending_chars.push_back(item);
      end
      chars_queued += expr_chars.size();
      expr_chars.delete();
   endtask

   task automatic add_random_expr();
      int pick;
      int pos;
      int count;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         if ($urandom_range(0, 9) == 0)
            add_operand_tree($urandom_range(9, 40));
         else
            add_operand_tree($urandom_range(0, 8));
      end else if (pick < 63) begin
         add_min_value_case();
      end else if (pick < 68) begin
         // Fill the stack close to the brim or past it, then fold part of it.
         count = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 6);
         repeat (count) expr_chars.push_back(random_digit());
         repeat ($urandom_range(0, 10)) expr_chars.push_back(random_operator());
      end else if (pick < 78) begin
         // Leftover operands below the result.
         add_operand_tree($urandom_range(0, 4));
         add_operand_tree($urandom_range(0, 4));
      end else if (pick < 88) begin
         // A well formed tree with one character broken.
         add_operand_tree($urandom_range(0, 6));
         pos = $urandom_range(0, expr_chars.size() - 1);
         if ($urandom_range(0, 1))
            expr_chars[pos] = 8'($urandom_range(0, 255));
         else
            expr_chars[pos] = random_operator();
      end else begin
         repeat ($urandom_range(1, 6)) expr_chars.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // Request driver: inputs change on the falling edge.
   always @(negedge clock) begin : drive_requests
      char_item_t next_item;
      logic       next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && chars_accepted != chars_issued)) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_chars.size() > 0 &&
                      !(pending_chars[0].drain && expected_results.size() > 0)) begin
            next_item = pending_chars.pop_front();
            req_symbol <= next_item.symbol;
            req_last <= next_item.last;
            chars_issued++;
            next_valid = 1'b1;
         end
         req_valid <= next_valid;
      end
   end

   // Response stall driver.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: predicts on each accepted character and checks each response.
   always @(posedge clock) begin : watch_channels
      eval_result_t want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            evaluate_char(req_symbol, req_last);
            chars_accepted++;
            if ($urandom_range(0, 63) == 0)
               req_calm = !req_calm;
            gap_left = req_calm ? 0 : $urandom_range(0, 7);
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected response %0d: value %0d status %0d",
                           results_seen, rsp_value, rsp_status);
            end else begin
               want = expected_results.pop_front();
               if (rsp_value !== want.value || rsp_status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Response %0d: expected value %0d status %0d, got value %0d status %0d",
                              results_seen, $signed(want.value), want.status,
                              rsp_value, rsp_status);
               end
            end
            if ($urandom_range(0, 63) == 0)
               rsp_calm = !rsp_calm;
            stall_left = rsp_calm ? 0 : $urandom_range(0, 7);
         end
      end
   end

   // Stimulus and end of test.
   initial begin : run_test
      int next_drain;
      int random_start;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed expressions: digit extremes, every operator, error cases.
      add_text("0");     commit_expr(1'b0);
      add_text("9");     commit_expr(1'b0);
      add_text("79-");   commit_expr(1'b0);
      add_text("89*");   commit_expr(1'b0);
      add_text("07-2/"); commit_expr(1'b0);
      add_text("07-2%"); commit_expr(1'b0);
      add_text("50/");   commit_expr(1'b0);
      add_text("30%");   commit_expr(1'b0);
      add_text("+");     commit_expr(1'b0);
      add_text("A");     commit_expr(1'b0);
      add_text("55");    commit_expr(1'b0);
      add_text("A50/");  commit_expr(1'b0);
      expr_chars.push_back(8'h00); commit_expr(1'b0);
      expr_chars.push_back(8'hFF); commit_expr(1'b0);

      // Random expressions, pausing now and then until the block drains.
      random_start = chars_queued;
      next_drain = chars_queued;
      while (chars_queued - random_start < RANDOM_CHARS) begin
         add_random_expr();
         if (chars_queued >= next_drain) begin
            commit_expr(1'b1);
            next_drain = chars_queued + $urandom_range(150, 300);
         end else begin
            commit_expr(1'b0);
         end
      end

      while (pending_chars.size() > 0 || chars_accepted != chars_issued)
         @(posedge clock);
      while (expected_results.size() > 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Run limit.
   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
